// ===== rtl/lkvc_pkg.sv =====
package lkvc_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int HITS_W     = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // stream payload layout
    localparam int IN_BITS    = 1 + KEY_BITS + VALUE_BITS;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + VALUE_BITS + HITS_W + CNT_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // apb register map
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] REG_MAX_ENTRIES = '0;
    localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = CNT_W'(CAPACITY);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_INSERT
    } state_t;

    typedef struct packed {
        logic capture;        // load the incoming transaction
        logic finish_lookup;  // apply get / set-hit and write the result
        logic evict;          // drop the oldest entry
        logic insert;         // insert new entry and write the result
    } cmd_t;

    typedef struct packed {
        logic is_set;
        logic match;
        logic need_evict;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/lkvc_ctrl.sv =====
module lkvc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lkvc_pkg::status_t status,
    output lkvc_pkg::cmd_t   cmd
);
    import lkvc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (status.is_set && !status.match) begin
                    state_next = status.need_evict ? ST_EVICT : ST_INSERT;
                end else if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EVICT: begin
                if (!status.need_evict) begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOOKUP: begin
                cmd.finish_lookup = !(status.is_set && !status.match) && status.out_free;
            end
            ST_EVICT: begin
                cmd.evict = status.need_evict;
            end
            ST_INSERT: begin
                cmd.insert = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.finish_lookup, cmd.evict, cmd.insert}))
        else $error("more than one datapath command at once");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == ST_LOOKUP)
        else $error("capture did not lead to lookup");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVICT && !status.need_evict) |=> state_reg == ST_INSERT)
        else $error("eviction end did not lead to insert");

endmodule

// ===== rtl/lkvc_datapath.sv =====
module lkvc_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [lkvc_pkg::CNT_W-1:0]             max_entries,
    input  logic                                   in_opcode,
    input  logic [lkvc_pkg::KEY_BITS-1:0]          in_key,
    input  logic [lkvc_pkg::VALUE_BITS-1:0]        in_value,
    input  lkvc_pkg::cmd_t                         cmd,
    output lkvc_pkg::status_t                      status,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic                                   out_hit,
    output logic [lkvc_pkg::VALUE_BITS-1:0]        out_value,
    output logic [lkvc_pkg::HITS_W-1:0]            out_hit_count,
    output logic [lkvc_pkg::CNT_W-1:0]             out_evicted,
    output logic [lkvc_pkg::CNT_W-1:0]             out_occupancy
);
    import lkvc_pkg::*;

    // entry storage, one lane per slot
    logic [CAPACITY-1:0]   valid_reg;
    logic [KEY_BITS-1:0]   key_reg   [CAPACITY];
    logic [VALUE_BITS-1:0] value_reg [CAPACITY];
    logic [HITS_W-1:0]     hits_reg  [CAPACITY];
    logic [IDX_W-1:0]      rank_reg  [CAPACITY];
    logic [CNT_W-1:0]      count_reg;

    // captured transaction
    logic                  op_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;
    logic [CNT_W-1:0]      evicted_reg;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] value_out_reg;
    logic [HITS_W-1:0]     hit_count_reg;
    logic [CNT_W-1:0]      evicted_out_reg;
    logic [CNT_W-1:0]      occupancy_reg;

    logic [CAPACITY-1:0]   match_vec;
    logic [CAPACITY-1:0]   victim_vec;
    logic [IDX_W-1:0]      match_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      hit_rank;
    logic [IDX_W-1:0]      oldest_rank;
    logic [HITS_W-1:0]     hits_inc;
    logic [CNT_W-1:0]      limit;
    logic                  match_any;
    logic                  get_hit;

    always_comb begin
        if (max_entries == '0) begin
            limit = CNT_W'(1);
        end else if (max_entries > CNT_W'(CAPACITY)) begin
            limit = CNT_W'(CAPACITY);
        end else begin
            limit = max_entries;
        end
    end

    assign oldest_rank = IDX_W'(count_reg - CNT_W'(1));

    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            match_vec[i]  = valid_reg[i] && (key_reg[i] == req_key_reg);
            victim_vec[i] = valid_reg[i] && (rank_reg[i] == oldest_rank);
            if (match_vec[i]) begin
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign match_any = |match_vec;
    assign get_hit   = match_any && (op_reg == OP_GET);
    assign hit_rank  = rank_reg[match_idx];
    assign hits_inc  = (&hits_reg[match_idx]) ? hits_reg[match_idx]
                                               : hits_reg[match_idx] + HITS_W'(1);

    assign status.is_set     = (op_reg == OP_SET);
    assign status.match      = match_any;
    assign status.need_evict = (count_reg >= limit) && (count_reg != '0);
    assign status.out_free   = !out_valid_reg || m_tready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish_lookup || cmd.insert) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.evict) begin
                valid_reg <= valid_reg & ~victim_vec;
                count_reg <= count_reg - CNT_W'(1);
            end else if (cmd.insert) begin
                valid_reg[free_idx] <= 1'b1;
                count_reg           <= count_reg + CNT_W'(1);
            end
        end
    end

    // entry payload and result register
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= in_opcode;
            req_key_reg   <= in_key;
            req_value_reg <= in_value;
            evicted_reg   <= '0;
        end
        if (cmd.evict) begin
            evicted_reg <= evicted_reg + CNT_W'(1);
        end

        if (cmd.finish_lookup) begin
            if (match_any) begin
                // touch: entries newer than the hit entry age by one
                for (int i = 0; i < CAPACITY; i++) begin
                    if (valid_reg[i] && rank_reg[i] < hit_rank) begin
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                    end
                end
                rank_reg[match_idx] <= '0;
                if (op_reg == OP_GET) begin
                    hits_reg[match_idx] <= hits_inc;
                end else begin
                    value_reg[match_idx] <= req_value_reg;
                    hits_reg[match_idx]  <= '0;
                end
            end
            hit_reg         <= match_any;
            value_out_reg   <= get_hit ? value_reg[match_idx] : '0;
            hit_count_reg   <= get_hit ? hits_inc : '0;
            evicted_out_reg <= '0;
            occupancy_reg   <= count_reg;
        end

        if (cmd.insert) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (valid_reg[i]) begin
                    rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                end
            end
            rank_reg[free_idx]  <= '0;
            key_reg[free_idx]   <= req_key_reg;
            value_reg[free_idx] <= req_value_reg;
            hits_reg[free_idx]  <= '0;
            hit_reg             <= 1'b0;
            value_out_reg       <= '0;
            hit_count_reg       <= '0;
            evicted_out_reg     <= evicted_reg;
            occupancy_reg       <= count_reg + CNT_W'(1);
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign out_hit       = hit_reg;
    assign out_value     = value_out_reg;
    assign out_hit_count = hit_count_reg;
    assign out_evicted   = evicted_out_reg;
    assign out_occupancy = occupancy_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count out of step with valid entries");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("key present in more than one entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |-> $onehot(victim_vec))
        else $error("eviction without a single oldest entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> !valid_reg[free_idx])
        else $error("insert into an occupied slot");

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// get and set of a present key: the s_tdata transaction is captured in idle, the result
// is registered in lookup, and the next transaction is taken once back in idle
// set of an absent key with room: lookup passes to insert, which registers the result
// a set that must drop n entries passes through evict before insert, one entry dropped per cycle
// a result held by m_tready low stalls the lookup and the insert, only one transaction is in flight
// synchronous active-low reset empties the cache and sets max_entries to 16
module lru_key_value_cache (
    input  logic                            aclk,
    input  logic                            aresetn,
    // opcode[0], key[32:1], value_in[64:33], zero pad
    input  logic [lkvc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // hit[0], value_out[32:1], hit_count[64:33], evicted[69:65], occupancy[74:70]
    output logic [lkvc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lkvc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import lkvc_pkg::*;

    logic [CNT_W-1:0]      max_entries_reg;
    logic                  cfg_write;
    cmd_t                  cmd;
    status_t               status;
    logic                  out_hit;
    logic [VALUE_BITS-1:0] out_value;
    logic [HITS_W-1:0]     out_hit_count;
    logic [CNT_W-1:0]      out_evicted;
    logic [CNT_W-1:0]      out_occupancy;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end else if (cfg_write && paddr[APB_ADDR_W-1:2] == REG_MAX_ENTRIES) begin
            max_entries_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_MAX_ENTRIES) begin
            prdata = {{(32 - CNT_W){1'b0}}, max_entries_reg};
        end
    end

    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lkvc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .max_entries   (max_entries_reg),
        .in_opcode     (s_tdata[0]),
        .in_key        (s_tdata[KEY_BITS:1]),
        .in_value      (s_tdata[KEY_BITS+VALUE_BITS:KEY_BITS+1]),
        .cmd           (cmd),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_hit       (out_hit),
        .out_value     (out_value),
        .out_hit_count (out_hit_count),
        .out_evicted   (out_evicted),
        .out_occupancy (out_occupancy)
    );

    assign m_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}},
                      out_occupancy, out_evicted, out_hit_count, out_value, out_hit};

endmodule
